FILE: hdl/rcw_pkg.sv
// rcw_pkg: shared types, constants and helper functions for the Reno
// congestion window sender core. No dependencies.
`timescale 1ns / 1ps
package rcw_pkg;

  localparam int SEQ_WIDTH  = 24;
  localparam int MAX_WINDOW = 64;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] Q_TWO   = 32'h0002_0000;
  localparam logic [31:0] Q_THREE = 32'h0003_0000;
  localparam logic [31:0] Q_MAX   = 32'hFFFF_FFFF;
  localparam logic [7:0]  DUP_MAX  = 8'd255;
  localparam logic [7:0]  DUP_TRIG = 8'd3;

  localparam logic [22:0] RST_INIT_WINDOW    = 23'd65536;
  localparam logic [22:0] RST_INIT_THRESHOLD = 23'd1048576;
  localparam logic [6:0]  RST_RECV_WINDOW    = 7'd64;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_RECV    = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    CLS_START     = 4'd0,
    CLS_NEW_ACK   = 4'd1,
    CLS_DUP       = 4'd2,
    CLS_DUP_IGN   = 4'd3,
    CLS_OLD       = 4'd4,
    CLS_BEYOND    = 4'd5,
    CLS_NOT_ACK   = 4'd6,
    CLS_MALFORMED = 4'd7,
    CLS_TIMEOUT   = 4'd8
  } cls_t;

  typedef enum logic [2:0] {
    REG_TOTAL     = 3'd0,
    REG_RECV_WIN  = 3'd1,
    REG_INIT_WIN  = 3'd2,
    REG_INIT_THR  = 3'd3,
    REG_FAST_RETX = 3'd4,
    REG_FAST_REC  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_TIMEOUT,
    KIND_MALFORMED,
    KIND_NOACK,
    KIND_ACK
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_GROW,
    ST_DIV,
    ST_WIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] ack_number;
    logic        ack_flag;
    logic        well_formed;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [23:0] send_sequence;
    logic        is_retransmit;
    logic        last;
    logic [3:0]  event_class;
    logic [31:0] window_now;
    logic [31:0] threshold_now;
    logic        recovery_now;
    logic [23:0] base_now;
    logic [23:0] next_now;
    logic        transfer_done;
  } out_item_t;

  typedef struct packed {
    logic [23:0] total_packets;
    logic [6:0]  recv_wnd;
    logic [22:0] initial_window;
    logic [22:0] initial_threshold;
    logic        fast_retransmit_on;
    logic        fast_recovery_on;
  } cfg_t;

  // classified event handed from front to back
  typedef struct packed {
    kind_t                 kind;
    logic [SEQ_WIDTH-1:0]  ack;
  } evt_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Q_MAX : s[31:0];
  endfunction

  function automatic logic [31:0] half_thr(input logic [31:0] w);
    logic [31:0] h;
    h = {1'b0, w[31:1]};
    return (h < Q_TWO) ? Q_TWO : h;
  endfunction

endpackage

FILE: hdl/rcw_front.sv
// rcw_front: accepts input beats, classifies the packet-independent part
// of each event and queues it for the back end. Depends on rcw_pkg.
`timescale 1ns / 1ps
module rcw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcw_pkg::in_item_t in_data,
  output logic              evt_valid,
  output rcw_pkg::evt_t     evt,
  input  logic              evt_pop
);

  rcw_pkg::evt_t mem_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  rcw_pkg::evt_t cls_evt;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign evt_valid = (cnt_r != 2'd0);
  assign evt       = mem_r[rptr_r];

  always_comb begin
    cls_evt.ack = in_data.ack_number[rcw_pkg::SEQ_WIDTH-1:0];
    unique case (in_data.func)
      rcw_pkg::FUNC_START:   cls_evt.kind = rcw_pkg::KIND_START;
      rcw_pkg::FUNC_TIMEOUT: cls_evt.kind = rcw_pkg::KIND_TIMEOUT;
      rcw_pkg::FUNC_RECV: begin
        if (!in_data.well_formed) cls_evt.kind = rcw_pkg::KIND_MALFORMED;
        else if (!in_data.ack_flag) cls_evt.kind = rcw_pkg::KIND_NOACK;
        else cls_evt.kind = rcw_pkg::KIND_ACK;
      end
      default: cls_evt.kind = rcw_pkg::KIND_MALFORMED;
    endcase
  end

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = evt_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, evt_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls_evt;
    end
  end

endmodule

FILE: hdl/rcw_div.sv
// rcw_div: radix-2 restoring divider computing 2^32 / divisor, one quotient
// bit per cycle (33 steps). No dependencies.
`timescale 1ns / 1ps
module rcw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [32:0] trial;
  logic        ge;

  // numerator is 2^32: only its top bit (step 32) is set
  assign trial = {rem_r, (cnt_r == 6'd32)};
  assign ge    = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      quo_nxt = {quo_r[31:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

endmodule

FILE: hdl/rcw_back.sv
// rcw_back: sender state, window update (slow start, congestion avoidance,
// fast retransmit/recovery, timeout) and send beat emission.
// Depends on rcw_pkg and rcw_div.
`timescale 1ns / 1ps
module rcw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rcw_pkg::cfg_t      cfg,
  input  logic               evt_valid,
  input  rcw_pkg::evt_t      evt,
  output logic               evt_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rcw_pkg::out_item_t out_data
);

  localparam int SW = rcw_pkg::SEQ_WIDTH;
  localparam int CW = rcw_pkg::CNT_W;

  rcw_pkg::state_t state_r, state_nxt;
  rcw_pkg::evt_t   evt_r;
  logic [SW-1:0]   base_r, base_nxt;
  logic [SW-1:0]   next_r, next_nxt;
  logic [31:0]     cwnd_r, cwnd_nxt;
  logic [31:0]     ssth_r, ssth_nxt;
  logic            rec_r, rec_nxt;
  logic [SW-1:0]   dupv_r, dupv_nxt;
  logic [7:0]      dupc_r, dupc_nxt;
  rcw_pkg::cls_t   cls_r, cls_nxt;
  logic            act_r, act_nxt;
  logic [SW-1:0]   acked_r, acked_nxt;
  logic [CW-1:0]   nretx_r, nretx_nxt;
  logic [CW-1:0]   nnew_r, nnew_nxt;
  logic [SW-1:0]   nseq_r, nseq_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            ovalid_r, ovalid_nxt;
  rcw_pkg::out_item_t odata_r, odata_nxt;

  logic        load;
  logic        grow_stop, grow_div;
  logic        div_done;
  logic [32:0] div_q;
  logic [31:0] div_inc;
  logic [7:0]  dupc_new;
  logic [SW-1:0] outst;
  logic [CW:0] ntot;
  logic        is_last;
  logic [6:0]  rw, w;
  logic [SW:0] limit, limgap;
  logic [SW-1:0] totgap;
  logic [CW-1:0] avail, nmin;

  assign load      = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign grow_stop = (acked_r == '0) || (cwnd_r == rcw_pkg::Q_MAX);
  assign grow_div  = !(cwnd_r < ssth_r) && (cwnd_r != '0);
  assign div_inc   = div_q[32] ? rcw_pkg::Q_MAX : div_q[31:0];
  assign ntot      = {1'b0, nretx_r} + {1'b0, nnew_r};
  assign is_last   = (ntot == '0) || ({1'b0, idx_r} == ntot - 1'b1);

  rcw_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == rcw_pkg::ST_GROW && !grow_stop && grow_div),
    .divisor (cwnd_r),
    .done    (div_done),
    .quot    (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcw_pkg::ST_IDLE:  if (evt_valid) state_nxt = rcw_pkg::ST_EVENT;
      rcw_pkg::ST_EVENT: state_nxt = rcw_pkg::ST_GROW;
      rcw_pkg::ST_GROW: begin
        if (grow_stop) state_nxt = rcw_pkg::ST_WIN;
        else if (grow_div) state_nxt = rcw_pkg::ST_DIV;
      end
      rcw_pkg::ST_DIV:   if (div_done) state_nxt = rcw_pkg::ST_GROW;
      rcw_pkg::ST_WIN:   state_nxt = rcw_pkg::ST_EMIT;
      rcw_pkg::ST_EMIT:  if (load && is_last) state_nxt = rcw_pkg::ST_IDLE;
      default:           state_nxt = rcw_pkg::ST_IDLE;
    endcase
  end

  assign evt_pop = (state_r == rcw_pkg::ST_IDLE) && evt_valid;

  // window arithmetic for the send count
  always_comb begin
    rw = cfg.recv_wnd;
    if (rw == 7'd0) rw = 7'd1;
    if (rw > 7'(rcw_pkg::MAX_WINDOW)) rw = 7'(rcw_pkg::MAX_WINDOW);
    if (cwnd_r[31:16] == 16'd0) w = 7'd1;
    else if (cwnd_r[31:16] > {9'd0, rw}) w = rw;
    else w = cwnd_r[22:16];
    limit  = {1'b0, base_r} + (SW+1)'(w);
    limgap = ({1'b0, next_r} < limit) ? limit - {1'b0, next_r} : '0;
    totgap = (next_r < cfg.total_packets) ? cfg.total_packets - next_r : '0;
    avail  = CW'(rcw_pkg::MAX_WINDOW) - nretx_r;
    nmin   = avail;
    if (totgap < SW'(nmin)) nmin = totgap[CW-1:0];
    if (limgap < (SW+1)'(nmin)) nmin = limgap[CW-1:0];
  end

  // datapath / outputs
  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    cwnd_nxt   = cwnd_r;
    ssth_nxt   = ssth_r;
    rec_nxt    = rec_r;
    dupv_nxt   = dupv_r;
    dupc_nxt   = dupc_r;
    cls_nxt    = cls_r;
    act_nxt    = act_r;
    acked_nxt  = acked_r;
    nretx_nxt  = nretx_r;
    nnew_nxt   = nnew_r;
    nseq_nxt   = nseq_r;
    idx_nxt    = idx_r;
    ovalid_nxt = load ? 1'b0 : ovalid_r;
    odata_nxt  = odata_r;
    dupc_new   = (evt_r.ack == dupv_r) ?
                 ((dupc_r < rcw_pkg::DUP_MAX) ? dupc_r + 8'd1 : dupc_r) : 8'd1;
    outst      = next_r - base_r;

    unique case (state_r)
      rcw_pkg::ST_IDLE: ;
      rcw_pkg::ST_EVENT: begin
        act_nxt   = 1'b0;
        acked_nxt = '0;
        nretx_nxt = '0;
        unique case (evt_r.kind)
          rcw_pkg::KIND_START: begin
            cls_nxt  = rcw_pkg::CLS_START;
            act_nxt  = 1'b1;
            base_nxt = '0;
            next_nxt = '0;
            cwnd_nxt = {9'd0, cfg.initial_window};
            ssth_nxt = {9'd0, cfg.initial_threshold};
            rec_nxt  = 1'b0;
            dupv_nxt = '0;
            dupc_nxt = '0;
          end
          rcw_pkg::KIND_TIMEOUT: begin
            cls_nxt   = rcw_pkg::CLS_TIMEOUT;
            act_nxt   = 1'b1;
            dupc_nxt  = '0;
            rec_nxt   = 1'b0;
            ssth_nxt  = rcw_pkg::half_thr(cwnd_r);
            cwnd_nxt  = rcw_pkg::Q_ONE;
            nretx_nxt = (outst > SW'(rcw_pkg::MAX_WINDOW)) ?
                        CW'(rcw_pkg::MAX_WINDOW) : outst[CW-1:0];
          end
          rcw_pkg::KIND_MALFORMED: cls_nxt = rcw_pkg::CLS_MALFORMED;
          rcw_pkg::KIND_NOACK:     cls_nxt = rcw_pkg::CLS_NOT_ACK;
          rcw_pkg::KIND_ACK: begin
            if (evt_r.ack < base_r) begin
              cls_nxt = rcw_pkg::CLS_OLD;
            end else if (evt_r.ack == base_r) begin
              if (!cfg.fast_retransmit_on) begin
                cls_nxt = rcw_pkg::CLS_DUP_IGN;
              end else begin
                cls_nxt  = rcw_pkg::CLS_DUP;
                act_nxt  = 1'b1;
                dupc_nxt = dupc_new;
                dupv_nxt = evt_r.ack;
                if (dupc_new == rcw_pkg::DUP_TRIG && base_r < next_r) begin
                  ssth_nxt  = rcw_pkg::half_thr(cwnd_r);
                  nretx_nxt = CW'(1);
                  if (cfg.fast_recovery_on) begin
                    cwnd_nxt = rcw_pkg::sat_add(rcw_pkg::half_thr(cwnd_r),
                                                rcw_pkg::Q_THREE);
                    rec_nxt  = 1'b1;
                  end else begin
                    cwnd_nxt = rcw_pkg::Q_ONE;
                    rec_nxt  = 1'b0;
                  end
                end else if (cfg.fast_recovery_on && rec_r &&
                             dupc_new > rcw_pkg::DUP_TRIG) begin
                  // window inflation during recovery
                  cwnd_nxt = rcw_pkg::sat_add(cwnd_r, rcw_pkg::Q_ONE);
                end
              end
            end else if (evt_r.ack > next_r) begin
              cls_nxt = rcw_pkg::CLS_BEYOND;
            end else begin
              cls_nxt  = rcw_pkg::CLS_NEW_ACK;
              act_nxt  = 1'b1;
              base_nxt = evt_r.ack;
              dupc_nxt = '0;
              dupv_nxt = evt_r.ack;
              if (rec_r) begin
                cwnd_nxt = ssth_r;
                rec_nxt  = 1'b0;
              end else begin
                acked_nxt = evt_r.ack - base_r;
              end
            end
          end
          default: cls_nxt = rcw_pkg::CLS_MALFORMED;
        endcase
      end
      rcw_pkg::ST_GROW: begin
        // one acked packet per pass; congestion avoidance goes via divider.
        // A zero window at or above threshold has a saturated reciprocal.
        if (!grow_stop && !grow_div) begin
          acked_nxt = acked_r - 1'b1;
          cwnd_nxt  = (cwnd_r < ssth_r) ?
                      rcw_pkg::sat_add(cwnd_r, rcw_pkg::Q_ONE) : rcw_pkg::Q_MAX;
        end
      end
      rcw_pkg::ST_DIV: begin
        if (div_done) begin
          acked_nxt = acked_r - 1'b1;
          cwnd_nxt  = rcw_pkg::sat_add(cwnd_r, div_inc);
        end
      end
      rcw_pkg::ST_WIN: begin
        nnew_nxt = act_r ? nmin : '0;
        nseq_nxt = next_r;
        next_nxt = next_r + SW'(act_r ? nmin : '0);
        idx_nxt  = '0;
      end
      rcw_pkg::ST_EMIT: begin
        if (load) begin
          ovalid_nxt              = 1'b1;
          idx_nxt                 = idx_r + 1'b1;
          odata_nxt.send_valid    = (ntot != '0);
          odata_nxt.last          = is_last;
          if (ntot == '0) begin
            odata_nxt.send_sequence = '0;
            odata_nxt.is_retransmit = 1'b0;
          end else if (idx_r < nretx_r) begin
            odata_nxt.send_sequence = base_r + SW'(idx_r);
            odata_nxt.is_retransmit = 1'b1;
          end else begin
            odata_nxt.send_sequence = nseq_r + SW'(idx_r - nretx_r);
            odata_nxt.is_retransmit = 1'b0;
          end
          odata_nxt.event_class   = cls_r;
          odata_nxt.window_now    = cwnd_r;
          odata_nxt.threshold_now = ssth_r;
          odata_nxt.recovery_now  = rec_r;
          odata_nxt.base_now      = base_r;
          odata_nxt.next_now      = next_r;
          odata_nxt.transfer_done = (base_r >= cfg.total_packets);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rcw_pkg::ST_IDLE;
      base_r   <= '0;
      next_r   <= '0;
      cwnd_r   <= {9'd0, rcw_pkg::RST_INIT_WINDOW};
      ssth_r   <= {9'd0, rcw_pkg::RST_INIT_THRESHOLD};
      rec_r    <= 1'b0;
      dupv_r   <= '0;
      dupc_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      next_r   <= next_nxt;
      cwnd_r   <= cwnd_nxt;
      ssth_r   <= ssth_nxt;
      rec_r    <= rec_nxt;
      dupv_r   <= dupv_nxt;
      dupc_r   <= dupc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) evt_r <= evt;
    cls_r   <= cls_nxt;
    act_r   <= act_nxt;
    acked_r <= acked_nxt;
    nretx_r <= nretx_nxt;
    nnew_r  <= nnew_nxt;
    nseq_r  <= nseq_nxt;
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
  end

endmodule

FILE: hdl/reno_congestion_window_sender_core.sv
// Reno congestion window sender core: configuration registers, event front
// end and sender back end. Depends on rcw_pkg, rcw_front, rcw_back.
// An accepted event waits in the front-end queue, then the back end steps
// through EVENT, GROW (per newly acked packet: a slow-start step, or a run of
// the 33-step reciprocal divider in congestion avoidance), WIN and EMIT.
// Throughput: one result beat per cycle while emitting and out_stall is low;
// a 2-entry event queue decouples input from the back end. Synchronous
// active-low reset; state and registers reset to defaults, no clearing pass.
`timescale 1ns / 1ps
module reno_congestion_window_sender_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcw_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rcw_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic          evt_valid, evt_pop;
  rcw_pkg::evt_t evt;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[4:2])
        rcw_pkg::REG_TOTAL:     cfg_nxt.total_packets      = pwdata[23:0];
        rcw_pkg::REG_RECV_WIN:  cfg_nxt.recv_wnd           = pwdata[6:0];
        rcw_pkg::REG_INIT_WIN:  cfg_nxt.initial_window     = pwdata[22:0];
        rcw_pkg::REG_INIT_THR:  cfg_nxt.initial_threshold  = pwdata[22:0];
        rcw_pkg::REG_FAST_RETX: cfg_nxt.fast_retransmit_on = pwdata[0];
        rcw_pkg::REG_FAST_REC:  cfg_nxt.fast_recovery_on   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      rcw_pkg::REG_TOTAL:     prdata = {8'd0, cfg_r.total_packets};
      rcw_pkg::REG_RECV_WIN:  prdata = {25'd0, cfg_r.recv_wnd};
      rcw_pkg::REG_INIT_WIN:  prdata = {9'd0, cfg_r.initial_window};
      rcw_pkg::REG_INIT_THR:  prdata = {9'd0, cfg_r.initial_threshold};
      rcw_pkg::REG_FAST_RETX: prdata = {31'd0, cfg_r.fast_retransmit_on};
      rcw_pkg::REG_FAST_REC:  prdata = {31'd0, cfg_r.fast_recovery_on};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_packets      <= '0;
      cfg_r.recv_wnd           <= rcw_pkg::RST_RECV_WINDOW;
      cfg_r.initial_window     <= rcw_pkg::RST_INIT_WINDOW;
      cfg_r.initial_threshold  <= rcw_pkg::RST_INIT_THRESHOLD;
      cfg_r.fast_retransmit_on <= 1'b1;
      cfg_r.fast_recovery_on   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_pop   (evt_pop)
  );

  rcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_pop   (evt_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sim/rcw_checker.sv
// rcw_checker: watches the event, result and register ports of the Reno sender
// core, keeps its own model of the window state and checks every result beat.
// Depends on rcw_pkg for the beat and register types.
`timescale 1ns / 1ps
module rcw_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rcw_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rcw_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 events_seen,
  output int                 sends_seen,
  output int                 retx_seen
);
  import rcw_pkg::*;

  // register copy
  logic [23:0] total_pkts;
  logic [6:0]  recv_win;
  logic [22:0] init_win;
  logic [22:0] init_thr;
  logic        fast_retx_en;
  logic        fast_rec_en;

  // window state copy
  logic [23:0] base_seq;
  logic [23:0] next_seq;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic        recovering;
  logic [23:0] dup_ack;
  logic [7:0]  dup_cnt;

  out_item_t expected_beats[$];

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Q_MAX : s[31:0];
  endfunction

  function automatic logic [31:0] halve(input logic [31:0] w);
    return ((w >> 1) < Q_TWO) ? Q_TWO : (w >> 1);
  endfunction

  task automatic load_start();
    base_seq = '0;
    next_seq = '0;
    cwnd = {9'd0, init_win};
    ssthresh = {9'd0, init_thr};
    recovering = 1'b0;
    dup_ack = '0;
    dup_cnt = '0;
  endtask

  task automatic predict_window(input in_item_t ev);
    logic [23:0] seqs[$];
    bit          retx[$];
    cls_t        cls;
    bit          act;
    logic [23:0] ack;
    logic [23:0] span;
    logic [63:0] recip;
    int          win;
    int          rw;
    longint      limit;
    out_item_t   e;
    act = 0;
    ack = ev.ack_number;
    if (ev.func == FUNC_START) begin
      cls = CLS_START;
      load_start();
      act = 1;
    end else if (ev.func == FUNC_TIMEOUT) begin
      cls = CLS_TIMEOUT;
      dup_cnt = '0;
      recovering = 1'b0;
      ssthresh = halve(cwnd);
      cwnd = Q_ONE;
      span = next_seq - base_seq;
      for (int s = 0; s < span && seqs.size() < MAX_WINDOW; s++) begin
        seqs.insert(seqs.size(), base_seq + s[23:0]);
        retx.insert(retx.size(), 1'b1);
      end
      act = 1;
    end else if (ev.func == FUNC_UNUSED || !ev.well_formed) begin
      cls = CLS_MALFORMED;
    end else if (!ev.ack_flag) begin
      cls = CLS_NOT_ACK;
    end else if (ack < base_seq) begin
      cls = CLS_OLD;
    end else if (ack == base_seq) begin
      if (!fast_retx_en) begin
        cls = CLS_DUP_IGN;
      end else begin
        cls = CLS_DUP;
        act = 1;
        if (ack == dup_ack) begin
          if (dup_cnt < DUP_MAX) dup_cnt++;
        end else begin
          dup_ack = ack;
          dup_cnt = 8'd1;
        end
        if (dup_cnt == DUP_TRIG && base_seq < next_seq) begin
          ssthresh = halve(cwnd);
          if (fast_rec_en) begin
            cwnd = add_sat(ssthresh, Q_THREE);
            recovering = 1'b1;
          end else begin
            cwnd = Q_ONE;
            recovering = 1'b0;
          end
          seqs.insert(seqs.size(), base_seq);
          retx.insert(retx.size(), 1'b1);
        end else if (fast_rec_en && recovering && dup_cnt > DUP_TRIG) begin
          cwnd = add_sat(cwnd, Q_ONE);
        end
      end
    end else if (ack > next_seq) begin
      cls = CLS_BEYOND;
    end else begin
      cls = CLS_NEW_ACK;
      act = 1;
      span = ack - base_seq;
      base_seq = ack;
      dup_cnt = '0;
      dup_ack = ack;
      if (recovering) begin
        cwnd = ssthresh;
        recovering = 1'b0;
      end else begin
        for (int c = 0; c < span && cwnd != Q_MAX; c++) begin
          if (cwnd < ssthresh) begin
            cwnd = add_sat(cwnd, Q_ONE);
          end else begin
            recip = (cwnd == 0) ? 64'hFFFF_FFFF : (64'h1_0000_0000 / cwnd);
            if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
            cwnd = add_sat(cwnd, recip[31:0]);
          end
        end
      end
    end

    if (act) begin
      rw = recv_win;
      if (rw < 1) rw = 1;
      if (rw > MAX_WINDOW) rw = MAX_WINDOW;
      win = cwnd[31:16];
      if (win < 1) win = 1;
      if (win > rw) win = rw;
      limit = longint'(base_seq) + win;
      while (seqs.size() < MAX_WINDOW && next_seq < total_pkts && longint'(next_seq) < limit) begin
        seqs.insert(seqs.size(), next_seq);
        retx.insert(retx.size(), 1'b0);
        next_seq = next_seq + 24'd1;
      end
    end

    e.event_class   = cls;
    e.window_now    = cwnd;
    e.threshold_now = ssthresh;
    e.recovery_now  = recovering;
    e.base_now      = base_seq;
    e.next_now      = next_seq;
    e.transfer_done = (base_seq >= total_pkts);
    if (seqs.size() == 0) begin
      e.send_valid = 1'b0;
      e.send_sequence = '0;
      e.is_retransmit = 1'b0;
      e.last = 1'b1;
      expected_beats.insert(expected_beats.size(), e);
    end else begin
      for (int k = 0; k < seqs.size(); k++) begin
        e.send_valid = 1'b1;
        e.send_sequence = seqs[k];
        e.is_retransmit = retx[k];
        e.last = (k == seqs.size() - 1);
        expected_beats.insert(expected_beats.size(), e);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      total_pkts   = '0;
      recv_win     = RST_RECV_WINDOW;
      init_win     = RST_INIT_WINDOW;
      init_thr     = RST_INIT_THRESHOLD;
      fast_retx_en = 1'b1;
      fast_rec_en  = 1'b1;
      base_seq     = '0;
      next_seq     = '0;
      cwnd         = {9'd0, RST_INIT_WINDOW};
      ssthresh     = {9'd0, RST_INIT_THRESHOLD};
      recovering   = 1'b0;
      dup_ack      = '0;
      dup_cnt      = '0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_TOTAL:     total_pkts   = pwdata[23:0];
          REG_RECV_WIN:  recv_win     = pwdata[6:0];
          REG_INIT_WIN:  init_win     = pwdata[22:0];
          REG_INIT_THR:  init_thr     = pwdata[22:0];
          REG_FAST_RETX: fast_retx_en = pwdata[0];
          REG_FAST_REC:  fast_rec_en  = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_window(in_data);
        events_seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_beats.pop_front();
          check_field("send_valid", e.send_valid, out_data.send_valid);
          check_field("send_sequence", e.send_sequence, out_data.send_sequence);
          check_field("is_retransmit", e.is_retransmit, out_data.is_retransmit);
          check_field("last", e.last, out_data.last);
          check_field("event_class", e.event_class, out_data.event_class);
          check_field("window_now", e.window_now, out_data.window_now);
          check_field("threshold_now", e.threshold_now, out_data.threshold_now);
          check_field("recovery_now", e.recovery_now, out_data.recovery_now);
          check_field("base_now", e.base_now, out_data.base_now);
          check_field("next_now", e.next_now, out_data.next_now);
          check_field("transfer_done", e.transfer_done, out_data.transfer_done);
          if (out_data.send_valid) sends_seen++;
          if (out_data.send_valid && out_data.is_retransmit) retx_seen++;
        end
      end
    end
    pending <= expected_beats.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    events_seen = 0;
    sends_seen = 0;
    retx_seen = 0;
  end

endmodule

FILE: sim/tb_top.sv
// tb_top: clock, reset, register writes and event stimulus for the Reno sender
// core; checking lives in rcw_checker. Depends on rcw_pkg, the core, rcw_checker.
`timescale 1ns / 1ps
module tb_top;
  import rcw_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int events_seen;
  int sends_seen;
  int retx_seen;
  int offered;
  int burst_left;
  logic [23:0] cur_ack;

  reno_congestion_window_sender_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rcw_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .events_seen(events_seen),
    .sends_seen(sends_seen), .retx_seen(retx_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #40ms;
    $display("FAIL reno_congestion_window_sender_core");
    $finish;
  end

  // receiver: one long hold-off once the sender is under way, then
  // stall patterns that change at random
  initial begin
    int hold;
    int mode;
    bit held;
    out_stall = 1'b0;
    held = 0;
    hold = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (!held && offered >= 40) begin
        held = 1;
        hold = 300;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 3) == 3);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] total, input logic [6:0] rw,
                            input logic [22:0] iw, input logic [22:0] ith,
                            input logic frx, input logic frc);
    reg_write(REG_TOTAL, {8'd0, total});
    reg_write(REG_RECV_WIN, {25'd0, rw});
    reg_write(REG_INIT_WIN, {9'd0, iw});
    reg_write(REG_INIT_THR, {9'd0, ith});
    reg_write(REG_FAST_RETX, {31'd0, frx});
    reg_write(REG_FAST_REC, {31'd0, frc});
  endtask

  function automatic in_item_t mk(input func_t f, input logic [23:0] ack,
                                  input logic flag, input logic wf);
    in_item_t it;
    it.func = f;
    it.ack_number = ack;
    it.ack_flag = flag;
    it.well_formed = wf;
    return it;
  endfunction

  function automatic logic [23:0] rnd_seq();
    return 24'($urandom);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom);
  endfunction

  task automatic send_event(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    offered++;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_events(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        cur_ack = '0;
        send_event(mk(FUNC_START, rnd_seq(), rnd_bit(), rnd_bit()));
      end else if (r < 12) begin
        send_event(mk(FUNC_TIMEOUT, rnd_seq(), rnd_bit(), rnd_bit()));
      end else if (r < 16) begin
        case ($urandom_range(0, 2))
          0: send_event(mk(FUNC_UNUSED, rnd_seq(), rnd_bit(), rnd_bit()));
          1: send_event(mk(FUNC_RECV, rnd_seq(), rnd_bit(), 1'b0));
          default: send_event(mk(FUNC_RECV, rnd_seq(), 1'b0, 1'b1));
        endcase
      end else if (r < 20) begin
        send_event(mk(FUNC_RECV, rnd_seq(), 1'b1, 1'b1));
      end else if (r < 45) begin
        send_event(mk(FUNC_RECV, cur_ack, 1'b1, 1'b1));
      end else begin
        cur_ack = cur_ack + 24'($urandom_range(1, 6));
        send_event(mk(FUNC_RECV, cur_ack, 1'b1, 1'b1));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    offered = 0;
    burst_left = 0;
    cur_ack = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default registers: nothing to send
    send_event(mk(FUNC_START, 24'd0, 1'b0, 1'b0));
    send_event(mk(FUNC_RECV, 24'd0, 1'b1, 1'b1));
    send_event(mk(FUNC_TIMEOUT, 24'hFFFFFF, 1'b1, 1'b1));
    send_event(mk(FUNC_UNUSED, 24'hFFFFFF, 1'b1, 1'b1));
    drain();

    // directed: slow start, duplicates into fast recovery, odd packets
    set_config(24'd40, 7'd64, 23'd65536, 23'd1048576, 1'b1, 1'b1);
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd1, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd3, 1'b1, 1'b1));
    repeat (5) send_event(mk(FUNC_RECV, 24'd3, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd2, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'hFFFFFF, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd5, 1'b0, 1'b1));
    send_event(mk(FUNC_RECV, 24'd5, 1'b1, 1'b0));
    send_event(mk(FUNC_RECV, 24'd6, 1'b1, 1'b1));
    send_event(mk(FUNC_TIMEOUT, 24'd0, 1'b0, 1'b0));
    send_event(mk(FUNC_RECV, 24'd40, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd12, 1'b1, 1'b1));
    drain();

    // fast retransmit off, big windows, congestion avoidance from the start
    set_config(24'hFFFFFF, 7'd64, 23'd4194304, 23'd4194304, 1'b0, 1'b1);
    cur_ack = '0;
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd64, 1'b1, 1'b1));
    send_event(mk(FUNC_RECV, 24'd64, 1'b1, 1'b1));
    cur_ack = 24'd64;
    random_events(25);
    drain();

    set_config(24'd200, 7'd1, 23'd4194304, 23'd65536, 1'b1, 1'b0);
    cur_ack = '0;
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    random_events(25);
    drain();

    set_config(24'd30, 7'd8, 23'd131072, 23'd196608, 1'b1, 1'b1);
    cur_ack = '0;
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    random_events(25);
    drain();

    // receiver window outside 1..64 gets clamped
    set_config(24'd100, 7'd127, 23'd65536, 23'd262144, 1'b1, 1'b1);
    cur_ack = '0;
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    random_events(25);
    drain();

    set_config(24'd50, 7'd0, 23'd1048576, 23'd65536, 1'b1, 1'b1);
    cur_ack = '0;
    send_event(mk(FUNC_START, 24'd0, 1'b1, 1'b1));
    random_events(25);
    drain();

    repeat (50) @(negedge clk);
    $display("Covered %0d events over 7 register settings: %0d sends, %0d retransmits.",
             events_seen, sends_seen, retx_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS reno_congestion_window_sender_core");
    end else begin
      $display("FAIL reno_congestion_window_sender_core");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rcw_pkg.sv
hdl/rcw_front.sv
hdl/rcw_div.sv
hdl/rcw_back.sv
hdl/reno_congestion_window_sender_core.sv
sim/rcw_checker.sv
sim/tb_top.sv
